// ----- rtl/l1vl2_pkg.sv -----
// Shared types, constants and codes for the L1 / victim / L2 tag model.
package l1vl2_pkg;

    localparam int VICTIM_ENTRIES_DEF = 4;
    localparam int L2_WAYS_DEF        = 8;
    localparam int SETS               = 16;
    localparam int TAG_W              = 6;
    localparam int IDX_W              = 4;
    localparam int KEY_W              = TAG_W + IDX_W;
    localparam int ADDR_W             = 12;
    localparam int CNT_W              = 32;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef enum logic [1:0] {
        OUT_L1_HIT  = 2'd0,
        OUT_VIC_HIT = 2'd1,
        OUT_L2_HIT  = 2'd2,
        OUT_MISS    = 2'd3
    } t_outcome;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_VINS,
        ST_L2INS,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] address;
    } t_req;

    typedef struct packed {
        logic [1:0]       outcome;
        logic [CNT_W-1:0] read_count;
        logic [CNT_W-1:0] l1_miss_count;
        logic [CNT_W-1:0] victim_miss_count;
        logic [CNT_W-1:0] l2_miss_count;
    } t_rsp;

    typedef struct packed {
        logic idle;
        logic lookup;
        logic vins;
        logic l2ins;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic req_valid;
        logic l1_evict;
        logic vic_full;
        logic out_free;
    } t_status;

endpackage

// ----- rtl/l1vl2_ctrl.sv -----
// Sequencer for lookup, victim insert, L2 insert and result hand-off.
module l1vl2_ctrl
    import l1vl2_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.idle = 1'b1;
                if (i_status.req_valid) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state = i_status.l1_evict ? ST_VINS : ST_DONE;
            end
            ST_VINS: begin
                o_cmd.vins = 1'b1;
                n_state = i_status.vic_full ? ST_L2INS : ST_DONE;
            end
            ST_L2INS: begin
                o_cmd.l2ins = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/l1vl2_dp.sv -----
// Tag stores, LRU ages, statistics counters and result register.
module l1vl2_dp
    import l1vl2_pkg::*;
#(
    parameter int VICTIM_ENTRIES = VICTIM_ENTRIES_DEF,
    parameter int L2_WAYS        = L2_WAYS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    output t_status o_status,
    input  logic    i_req_valid,
    input  t_req    i_req,
    output logic    o_rsp_valid,
    input  logic    i_rsp_stall,
    output t_rsp    o_rsp
);

    localparam int VA_W  = (VICTIM_ENTRIES > 1) ? $clog2(VICTIM_ENTRIES) : 1;
    localparam int LA_W  = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
    localparam int WAY_W = TAG_W + LA_W;
    localparam int ROW_W = L2_WAYS * WAY_W;

    logic                 r_rd;
    logic [TAG_W-1:0]     r_tag;
    logic [IDX_W-1:0]     r_set;

    logic [SETS-1:0]      r_l1_valid;
    logic [TAG_W-1:0]     r_l1_tag [SETS];

    logic [VICTIM_ENTRIES-1:0] r_vic_valid, n_vic_valid;
    logic [KEY_W-1:0]     r_vic_key [VICTIM_ENTRIES];
    logic [KEY_W-1:0]     n_vic_key [VICTIM_ENTRIES];
    logic [VA_W-1:0]      r_vic_age [VICTIM_ENTRIES];
    logic [VA_W-1:0]      n_vic_age [VICTIM_ENTRIES];

    logic [L2_WAYS-1:0]   r_l2_valid [SETS];
    logic [ROW_W-1:0]     l2_mem [SETS];
    logic [ROW_W-1:0]     r_l2_rdata;

    logic [CNT_W-1:0]     r_cnt [4];
    logic [KEY_W-1:0]     r_old_key;
    logic [KEY_W-1:0]     r_evict_key;
    t_outcome             r_outcome;
    logic                 r_out_valid;
    t_rsp                 r_rsp;

    logic                 accept;
    logic                 l1_hit;
    logic [VICTIM_ENTRIES-1:0] vic_match;
    logic                 vic_hit;
    logic [VA_W-1:0]      vic_w;
    logic [L2_WAYS-1:0]   l2_match;
    logic                 l2_hit;
    logic [LA_W-1:0]      l2_w;
    logic                 vic_op;
    logic                 l2_op;
    t_outcome             outcome;
    logic                 vic_full;
    logic [VA_W-1:0]      ins_w;
    logic [IDX_W-1:0]     rd_set;

    logic [IDX_W-1:0]     ins_set;
    logic [TAG_W-1:0]     ins_tag;
    logic [L2_WAYS-1:0]   ins_vrow;
    logic [LA_W-1:0]      l2_ins_w;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_set;
    logic [ROW_W-1:0]     wr_row;
    logic [L2_WAYS-1:0]   wr_vrow;

    assign accept = i_req_valid && i_cmd.idle;

    // lookup in all three levels
    always_comb begin
        l1_hit = r_l1_valid[r_set] && (r_l1_tag[r_set] == r_tag);
        vic_w  = '0;
        for (int i = VICTIM_ENTRIES - 1; i >= 0; i--) begin
            vic_match[i] = r_vic_valid[i] && (r_vic_key[i] == {r_tag, r_set});
            if (vic_match[i]) vic_w = VA_W'(i);
        end
        vic_hit = |vic_match;
        l2_w    = '0;
        for (int i = L2_WAYS - 1; i >= 0; i--) begin
            l2_match[i] = r_l2_valid[r_set][i] &&
                          (r_l2_rdata[i*WAY_W +: TAG_W] == r_tag);
            if (l2_match[i]) l2_w = LA_W'(i);
        end
        l2_hit = |l2_match;
        vic_op = !(r_rd && l1_hit) && vic_hit;
        l2_op  = !(r_rd && l1_hit) && !vic_hit && l2_hit;
        if (r_rd && l1_hit) outcome = OUT_L1_HIT;
        else if (vic_hit)   outcome = OUT_VIC_HIT;
        else if (l2_hit)    outcome = OUT_L2_HIT;
        else                outcome = OUT_MISS;
    end

    // victim slot for an insert: oldest when full, else lowest free
    always_comb begin
        vic_full = &r_vic_valid;
        ins_w    = '0;
        for (int i = VICTIM_ENTRIES - 1; i >= 0; i--) begin
            if (vic_full) begin
                if (r_vic_age[i] == VA_W'(VICTIM_ENTRIES - 1)) ins_w = VA_W'(i);
            end else if (!r_vic_valid[i]) begin
                ins_w = VA_W'(i);
            end
        end
        rd_set = i_cmd.vins ? r_vic_key[ins_w][IDX_W-1:0] : i_req.address[5:2];
    end

    always_comb begin
        n_vic_valid = r_vic_valid;
        n_vic_key   = r_vic_key;
        n_vic_age   = r_vic_age;
        if (i_cmd.lookup && vic_op) begin
            if (r_rd) begin
                n_vic_valid[vic_w] = 1'b0;
                for (int i = 0; i < VICTIM_ENTRIES; i++) begin
                    if (r_vic_valid[i] && r_vic_age[i] > r_vic_age[vic_w])
                        n_vic_age[i] = r_vic_age[i] - VA_W'(1);
                end
            end else begin
                for (int i = 0; i < VICTIM_ENTRIES; i++) begin
                    if (r_vic_valid[i] && r_vic_age[i] < r_vic_age[vic_w])
                        n_vic_age[i] = r_vic_age[i] + VA_W'(1);
                end
                n_vic_age[vic_w] = '0;
            end
        end else if (i_cmd.vins) begin
            for (int i = 0; i < VICTIM_ENTRIES; i++) begin
                if (VA_W'(i) != ins_w && r_vic_valid[i])
                    n_vic_age[i] = r_vic_age[i] + VA_W'(1);
            end
            n_vic_valid[ins_w] = 1'b1;
            n_vic_key[ins_w]   = r_old_key;
            n_vic_age[ins_w]   = '0;
        end
    end

    // L2 row updates: remove or touch at lookup, insert of the evicted line
    always_comb begin
        ins_set  = r_evict_key[IDX_W-1:0];
        ins_tag  = r_evict_key[KEY_W-1:IDX_W];
        ins_vrow = r_l2_valid[ins_set];
        l2_ins_w = '0;
        for (int i = L2_WAYS - 1; i >= 0; i--) begin
            if (&ins_vrow) begin
                if (r_l2_rdata[i*WAY_W+TAG_W +: LA_W] == LA_W'(L2_WAYS - 1))
                    l2_ins_w = LA_W'(i);
            end else if (!ins_vrow[i]) begin
                l2_ins_w = LA_W'(i);
            end
        end

        wr_en   = 1'b0;
        wr_set  = r_set;
        wr_row  = r_l2_rdata;
        wr_vrow = r_l2_valid[r_set];
        if (i_cmd.lookup && l2_op) begin
            wr_en = 1'b1;
            if (r_rd) begin
                wr_vrow[l2_w] = 1'b0;
                for (int i = 0; i < L2_WAYS; i++) begin
                    if (r_l2_valid[r_set][i] &&
                        r_l2_rdata[i*WAY_W+TAG_W +: LA_W] >
                        r_l2_rdata[l2_w*WAY_W+TAG_W +: LA_W])
                        wr_row[i*WAY_W+TAG_W +: LA_W] =
                            r_l2_rdata[i*WAY_W+TAG_W +: LA_W] - LA_W'(1);
                end
            end else begin
                for (int i = 0; i < L2_WAYS; i++) begin
                    if (r_l2_valid[r_set][i] &&
                        r_l2_rdata[i*WAY_W+TAG_W +: LA_W] <
                        r_l2_rdata[l2_w*WAY_W+TAG_W +: LA_W])
                        wr_row[i*WAY_W+TAG_W +: LA_W] =
                            r_l2_rdata[i*WAY_W+TAG_W +: LA_W] + LA_W'(1);
                end
                wr_row[l2_w*WAY_W+TAG_W +: LA_W] = '0;
            end
        end else if (i_cmd.l2ins) begin
            wr_en   = 1'b1;
            wr_set  = ins_set;
            wr_vrow = ins_vrow;
            for (int i = 0; i < L2_WAYS; i++) begin
                if (LA_W'(i) != l2_ins_w && ins_vrow[i])
                    wr_row[i*WAY_W+TAG_W +: LA_W] =
                        r_l2_rdata[i*WAY_W+TAG_W +: LA_W] + LA_W'(1);
            end
            wr_vrow[l2_ins_w] = 1'b1;
            wr_row[l2_ins_w*WAY_W +: TAG_W] = ins_tag;
            wr_row[l2_ins_w*WAY_W+TAG_W +: LA_W] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l2_rdata <= l2_mem[rd_set];
        if (wr_en) begin
            l2_mem[wr_set] <= wr_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SETS; i++) r_l2_valid[i] <= '0;
        end else if (wr_en) begin
            r_l2_valid[wr_set] <= wr_vrow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vic_valid <= '0;
        end else begin
            r_vic_valid <= n_vic_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vic_key <= n_vic_key;
        r_vic_age <= n_vic_age;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd  <= i_req.action == ACT_READ;
            r_tag <= i_req.address[11:6];
            r_set <= i_req.address[5:2];
        end
        if (i_cmd.lookup) begin
            r_outcome <= outcome;
            if (r_rd && !l1_hit) begin
                r_old_key       <= {r_l1_tag[r_set], r_set};
                r_l1_tag[r_set] <= r_tag;
            end
        end
        if (i_cmd.vins) begin
            r_evict_key <= r_vic_key[ins_w];
        end
        if (i_cmd.load_out) begin
            r_rsp.outcome           <= r_outcome;
            r_rsp.read_count        <= r_cnt[0];
            r_rsp.l1_miss_count     <= r_cnt[1];
            r_rsp.victim_miss_count <= r_cnt[2];
            r_rsp.l2_miss_count     <= r_cnt[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1_valid  <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 4; i++) r_cnt[i] <= '0;
        end else begin
            if (i_cmd.lookup && r_rd) begin
                if (r_cnt[0] != '1) r_cnt[0] <= r_cnt[0] + CNT_W'(1);
                if (!l1_hit) begin
                    r_l1_valid[r_set] <= 1'b1;
                    if (r_cnt[1] != '1) r_cnt[1] <= r_cnt[1] + CNT_W'(1);
                    if (!vic_hit) begin
                        if (r_cnt[2] != '1) r_cnt[2] <= r_cnt[2] + CNT_W'(1);
                        if (!l2_hit && r_cnt[3] != '1) r_cnt[3] <= r_cnt[3] + CNT_W'(1);
                    end
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.req_valid = i_req_valid;
    assign o_status.l1_evict  = r_rd && !l1_hit && r_l1_valid[r_set];
    assign o_status.vic_full  = vic_full;
    assign o_status.out_free  = !r_out_valid || !i_rsp_stall;

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_rsp;

endmodule

// ----- rtl/l1_victim_l2_cache_tag_model.sv -----
// Top level of the L1 / victim buffer / L2 exclusive tag model.
//
//  channel   direction  valid         stall         payload
//  request   in         i_req_valid   o_req_stall   i_req (t_req)
//  response  out        o_rsp_valid   i_rsp_stall   o_rsp (t_rsp)
//
// One request at a time: lookup; victim insert when the displaced L1 line
// enters the victim buffer; L2 insert when that pushes a line into L2; hand-off
// (one L2 row read and one row write per step, one read and one write port).
// Synchronous active-low reset clears valid bits and counters; no clearing pass.
// A stalled response holds the block in its final step until taken.
module l1_victim_l2_cache_tag_model
    import l1vl2_pkg::*;
#(
    parameter int VICTIM_ENTRIES = VICTIM_ENTRIES_DEF,
    parameter int L2_WAYS        = L2_WAYS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp
);

    t_cmd    cmd;
    t_status status;

    l1vl2_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    l1vl2_dp #(
        .VICTIM_ENTRIES (VICTIM_ENTRIES),
        .L2_WAYS        (L2_WAYS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_req_valid (i_req_valid),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    assign o_req_stall = !cmd.idle;

endmodule
